// ----- src/dhsc_pkg.sv -----
// Shared types, constants and lookup functions for the diatonic harmony shift calculator.
package dhsc_pkg;

    localparam int KEY_W    = 4;
    localparam int NOTE_W   = 4;
    localparam int SHIFT_W  = 9;
    localparam int PITCH_W  = 16;
    localparam int DIST_W   = 11;
    localparam int RND_W    = 5;   // rounded interval, 0..26
    localparam int FRAC_W   = 5;   // interval fraction, -8..8
    localparam int DEG_W    = 3;
    localparam int SEMI_W   = 7;   // semitone above 27.5 Hz, 0..87
    localparam int N_HARM   = 3;

    // Semitone boundary table
    localparam int TH_N     = 128;
    localparam int TH_W     = 17;
    localparam int TH_KMAX  = 96;
    localparam int PW_W     = 416;
    localparam int POW_EXP  = 24;
    localparam int BASE_Q4  = 440;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam logic REG_KEY_IDX = 1'b0;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;

    typedef logic [NOTE_W-1:0] t_note;

    typedef struct packed {
        logic                   zero;
        logic [PITCH_W-1:0]     pitch;
        logic [DIST_W-1:0]      hand_dist;
        logic [RND_W-1:0]       rnd;
        t_note                  root;
    } t_item;

    typedef struct packed {
        logic signed [N_HARM-1:0][SHIFT_W-1:0] shift;
        t_note [N_HARM-1:0]                    harm;
        t_note                                 note;
    } t_rslt;

    // Smallest pitch p with p^24 >= 440^24 * 2^(2k-1), for every boundary k.
    // Boundaries beyond the pitch range read as all ones.
    function automatic logic [TH_N*TH_W-1:0] f_build_th();
        logic [TH_N*TH_W-1:0] tab;
        logic [PW_W-1:0]      base;
        logic [PW_W-1:0]      rhs;
        logic [PW_W-1:0]      pw;
        logic [TH_W-1:0]      lo;
        logic [TH_W-1:0]      cand;
        int                   k;
        int                   b;
        int                   i;
        base = PW_W'(1);
        for (i = 0; i < POW_EXP; i++) base = base * PW_W'(BASE_Q4);
        tab = '0;
        for (k = 1; k < TH_N; k++) begin
            if (k > TH_KMAX) begin
                tab[k*TH_W +: TH_W] = '1;
            end else begin
                rhs = base << (2*k - 1);
                lo  = '0;
                for (b = TH_W-1; b >= 0; b--) begin
                    cand = lo | (TH_W'(1) << b);
                    pw   = PW_W'(1);
                    for (i = 0; i < POW_EXP; i++) pw = pw * PW_W'(cand);
                    if (pw < rhs) lo = cand;
                end
                tab[k*TH_W +: TH_W] = lo + TH_W'(1);
            end
        end
        return tab;
    endfunction

    localparam logic [TH_N*TH_W-1:0] TH_TAB = f_build_th();

    function automatic logic [TH_W-1:0] f_th(input logic [SEMI_W-1:0] idx);
        return TH_TAB[idx*TH_W +: TH_W];
    endfunction

    // s mod 12 through a reciprocal multiply, exact for s below 128
    function automatic t_note f_mod12(input logic [SEMI_W-1:0] s);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  rem;
        prod = 15'(s) * 15'd171;
        q    = prod[14:11];
        rem  = s - 7'(q) * 7'd12;
        return rem[NOTE_W-1:0];
    endfunction

    function automatic t_note f_step(input logic [DEG_W-1:0] idx);
        t_note st;
        unique case (idx)
            3'd0:    st = 4'd0;
            3'd1:    st = 4'd2;
            3'd2:    st = 4'd4;
            3'd3:    st = 4'd5;
            3'd4:    st = 4'd7;
            3'd5:    st = 4'd9;
            3'd6:    st = 4'd11;
            default: st = 4'd0;
        endcase
        return st;
    endfunction

    // {in scale, degree} for a note given relative to the key root
    function automatic logic [DEG_W:0] f_deg_rel(input t_note rel);
        logic [DEG_W:0] r;
        unique case (rel)
            4'd0:    r = {1'b1, 3'd0};
            4'd2:    r = {1'b1, 3'd1};
            4'd4:    r = {1'b1, 3'd2};
            4'd5:    r = {1'b1, 3'd3};
            4'd7:    r = {1'b1, 3'd4};
            4'd9:    r = {1'b1, 3'd5};
            4'd11:   r = {1'b1, 3'd6};
            default: r = {1'b0, 3'd0};
        endcase
        return r;
    endfunction

    // Scale degree; a note off the scale takes the degree of the note below,
    // except the lowest note class, which falls back to degree 0.
    function automatic logic [DEG_W-1:0] f_degree(input t_note root, input t_note note);
        t_note          rel;
        logic [DEG_W:0] hit;
        logic [DEG_W:0] low;
        rel = (note >= root) ? t_note'(note - root) : t_note'(note + 4'd12 - root);
        hit = f_deg_rel(rel);
        low = f_deg_rel(t_note'(rel - 4'd1));
        if (hit[DEG_W])       return hit[DEG_W-1:0];
        else if (note == '0)  return '0;
        else                  return low[DEG_W-1:0];
    endfunction

endpackage

// ----- src/dhsc_front.sv -----
// Front end: accepts input transactions and classifies them into queue entries.
module dhsc_front (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dhsc_pkg::S_TDATA_W-1:0]    i_data,
    input  logic [dhsc_pkg::KEY_W-1:0]        i_key,
    input  logic                              i_q_full,
    output logic                              o_push,
    output dhsc_pkg::t_item                   o_item
);
    import dhsc_pkg::*;

    logic [PITCH_W-1:0] pitch;
    logic [DIST_W-1:0]  hand_dist;
    logic [11:0]        dsum;
    logic [7:0]         dq16;
    logic [14:0]        rprod;
    logic [KEY_W:0]     key3;

    assign pitch     = i_data[PITCH_W-1:0];
    assign hand_dist = i_data[PITCH_W +: DIST_W];

    // round(hand_dist / 80), halves up: (hand_dist + 40) >> 4, then divide by 5
    assign dsum  = 12'(hand_dist) + 12'd40;
    assign dq16  = dsum[11:4];
    assign rprod = 15'(dq16) * 15'd205;

    // key root with A as 0
    assign key3  = 5'(i_key) + 5'd3;

    always_comb begin
        o_item.zero      = (pitch == '0);
        o_item.pitch     = pitch;
        o_item.hand_dist = hand_dist;
        o_item.rnd       = rprod[14:10];
        o_item.root      = (key3 >= 5'd12) ? NOTE_W'(key3 - 5'd12) : NOTE_W'(key3);
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// ----- src/dhsc_queue.sv -----
// Short queue between the front end and the back end.
module dhsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dhsc_pkg::t_item   i_item,
    output logic              o_full,
    input  logic              i_pop,
    output dhsc_pkg::t_item   o_item,
    output logic              o_empty
);
    import dhsc_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_PTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- src/dhsc_back.sv -----
// Back end: semitone search pipeline, scale degree, harmony notes and shifts.
module dhsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dhsc_pkg::t_item   i_item,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output dhsc_pkg::t_rslt   o_rslt
);
    import dhsc_pkg::*;

    localparam int NS = SEMI_W;   // one search step per bit of the semitone

    logic                  en;

    // search stages
    logic                  r_sv   [NS+1];
    t_item                 r_sit  [NS+1];
    logic [SEMI_W-1:0]     r_sacc [NS+1];
    logic [SEMI_W-1:0]     n_sacc [NS+1];

    // note class stage
    logic                  r_mv;
    t_item                 r_mit;
    t_note                 r_mnote;
    logic signed [6:0]     r_me;
    logic [N_HARM-1:0][DEG_W-1:0] r_mrm;
    logic signed [6:0]     n_me;
    logic [N_HARM-1:0][DEG_W-1:0] n_mrm;

    // degree stage
    logic                  r_dv;
    t_item                 r_dit;
    t_note                 r_dnote;
    logic [DEG_W-1:0]      r_ddeg;
    logic signed [FRAC_W-1:0] r_dfrac;
    logic [N_HARM-1:0][DEG_W-1:0] r_drm;
    logic signed [FRAC_W-1:0] n_dfrac;

    // harmony stage
    logic                  r_hv;
    logic                  r_hzero;
    t_note                 r_hnote;
    t_note [N_HARM-1:0]    r_hh;
    logic signed [FRAC_W-1:0] r_hfrac;
    t_note [N_HARM-1:0]    n_hh;

    // output register
    logic                  r_ov;
    t_rslt                 r_o;
    t_rslt                 n_o;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_q_empty;

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            logic [SEMI_W-1:0] cand;
            cand = r_sacc[j] | (SEMI_W'(1) << (NS-1-j));
            n_sacc[j+1] = ({1'b0, r_sit[j].pitch} >= f_th(cand)) ? cand : r_sacc[j];
        end
        n_sacc[0] = '0;
    end

    // hand-distance remainder and interval multiples mod 7
    always_comb begin
        logic signed [12:0] e13;
        logic [11:0]        r80;
        for (int m = 0; m < N_HARM; m++) begin
            logic [6:0]  v;
            logic [11:0] p;
            logic [3:0]  q;
            logic [6:0]  rem;
            v   = 7'(r_sit[NS].rnd) * 7'(m + 1);
            p   = 12'(v) * 12'd37;
            q   = p[11:8];
            rem = v - 7'(q) * 7'd7;
            n_mrm[m] = rem[DEG_W-1:0];
        end
        r80  = {1'b0, r_sit[NS].rnd, 6'b0} + {3'b0, r_sit[NS].rnd, 4'b0};
        e13  = signed'(13'(r_sit[NS].hand_dist)) - signed'(13'(r80));
        n_me = e13[6:0];
    end

    always_comb begin
        logic        neg;
        logic [6:0]  mag;
        logic [5:0]  a;
        logic [9:0]  p;
        logic [3:0]  q;
        neg = r_me[6];
        mag = neg ? 7'(-r_me) : 7'(r_me);
        a   = 6'(mag) + 6'd2;
        p   = 10'(a) * 10'd13;
        q   = p[9:6];
        n_dfrac = neg ? -signed'(FRAC_W'(q)) : signed'(FRAC_W'(q));
    end

    always_comb begin
        for (int m = 0; m < N_HARM; m++) begin
            logic [3:0] idx;
            logic [4:0] hs;
            idx = 4'(r_ddeg) + 4'(r_drm[m]);
            if (idx >= 4'd7) idx = idx - 4'd7;
            hs  = 5'(r_dit.root) + 5'(f_step(idx[DEG_W-1:0]));
            n_hh[m] = (hs >= 5'd12) ? NOTE_W'(hs - 5'd12) : NOTE_W'(hs);
        end
    end

    always_comb begin
        for (int m = 0; m < N_HARM; m++) begin
            logic signed [9:0] s;
            s = signed'({1'b0, r_hh[m], 4'b0}) - signed'({1'b0, r_hnote, 4'b0})
                + 10'(r_hfrac);
            if (s > 10'sd96) s = s - 10'sd192;
            n_o.shift[m] = r_hzero ? '0 : s[SHIFT_W-1:0];
            n_o.harm[m]  = r_hzero ? '0 : r_hh[m];
        end
        n_o.note = r_hzero ? '0 : r_hnote;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) r_sv[j] <= 1'b0;
            r_mv <= 1'b0;
            r_dv <= 1'b0;
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= o_pop;
            for (int j = 0; j < NS; j++) r_sv[j+1] <= r_sv[j];
            r_mv <= r_sv[NS];
            r_dv <= r_mv;
            r_hv <= r_dv;
            r_ov <= r_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sit[0]  <= i_item;
            r_sacc[0] <= n_sacc[0];
            for (int j = 0; j < NS; j++) begin
                r_sit[j+1]  <= r_sit[j];
                r_sacc[j+1] <= n_sacc[j+1];
            end
            r_mit   <= r_sit[NS];
            r_mnote <= f_mod12(r_sacc[NS]);
            r_me    <= n_me;
            r_mrm   <= n_mrm;
            r_dit   <= r_mit;
            r_dnote <= r_mnote;
            r_ddeg  <= f_degree(r_mit.root, r_mnote);
            r_dfrac <= n_dfrac;
            r_drm   <= r_mrm;
            r_hzero <= r_dit.zero;
            r_hnote <= r_dnote;
            r_hh    <= n_hh;
            r_hfrac <= r_dfrac;
            r_o     <= n_o;
        end
    end

    assign o_valid = r_ov;
    assign o_rslt  = r_o;

endmodule

// ----- src/diatonic_harmony_shift_calc_core.sv -----
// Top level of the diatonic harmony shift calculator: stream ports, APB register, front/back.
// One result transaction per input transaction. A pitch is matched to its nearest semitone
// (A = 0) by a seven-step binary search over a constant table of boundary pitches, one
// step per pipeline stage, then the scale degree in the major key set by key_signature
// (APB byte address 0, C = 0) is looked up, and three harmony notes at 1x, 2x and 3x the
// rounded hand-distance interval are formed with their shifts in Q4 semitones. The block
// takes one transaction per clock while its 4-entry input queue is not full; an accepted
// transaction passes through the queue, eight search stages, then note class, degree and
// harmony stages and the output register. The whole back pipeline holds while a result
// waits on m_axis_tready; the queue keeps s_axis_tready high until it fills. A zero pitch
// gives an all-zero result. There is no clearing pass after reset.
module diatonic_harmony_shift_calc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] pitch_hz, [26:16] hand_distance, [31:27] zero
    input  logic [dhsc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] input_note, [7:4] harmony_one_note, [11:8] harmony_two_note,
    // [15:12] harmony_three_note, [24:16] harmony_one_shift,
    // [33:25] harmony_two_shift, [42:34] harmony_three_shift, [47:43] zero
    output logic [dhsc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dhsc_pkg::ADDR_W-1:0]       paddr,
    input  logic [dhsc_pkg::DATA_W-1:0]       pwdata,
    output logic [dhsc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import dhsc_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             cfg_wr;
    logic             sel_key;

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    t_item            front_item;
    t_item            q_item;
    t_rslt            rslt;

    // APB: zero-wait-state, word index taken from paddr[2]
    assign pready  = 1'b1;
    assign sel_key = (paddr[ADDR_W-1] == REG_KEY_IDX);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = sel_key ? DATA_W'(r_key) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (cfg_wr && sel_key) begin
            r_key <= pwdata[KEY_W-1:0];
        end
    end

    // classify each incoming transaction and push it into the queue
    dhsc_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_key    (r_key),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    dhsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    // pop whenever the pipeline advances; hold everything while the result stalls
    dhsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (q_item),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rslt    (rslt)
    );

    assign m_axis_tdata = M_TDATA_W'({rslt.shift[2], rslt.shift[1], rslt.shift[0],
                                      rslt.harm[2], rslt.harm[1], rslt.harm[0],
                                      rslt.note});

endmodule

// ----- src/dhsc_chk.sv -----
// Port-level checker for the harmony shift calculator, bound to the top level.
module dhsc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // reset drains the pipeline
    a_rst_drain: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // note classes stay within one octave
    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] < 4'd12 && m_axis_tdata[7:4] < 4'd12
                          && m_axis_tdata[11:8] < 4'd12 && m_axis_tdata[15:12] < 4'd12)
        else $error("note class out of range");

    // shifts never exceed half an octave upward
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[24:16]) <= 9'sd96
                          && $signed(m_axis_tdata[33:25]) <= 9'sd96
                          && $signed(m_axis_tdata[42:34]) <= 9'sd96)
        else $error("shift above 96");

    // key register reads back what was written
    a_key_rdbk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> paddr[2] || prdata[3:0] == $past(pwdata[3:0]))
        else $error("key readback mismatch");

endmodule

bind diatonic_harmony_shift_calc_core dhsc_chk u_dhsc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);

// ----- verif/harmony_shift_watch.sv -----
// Watches the stream and APB channels, predicts each harmony result and compares it field by field.
module harmony_shift_watch (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // [15:0] pitch_hz, [26:16] hand_distance, [31:27] zero
    input  logic [dhsc_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // [3:0] input_note, [7:4] [11:8] [15:12] harmony notes,
    // [24:16] [33:25] [42:34] harmony shifts, [47:43] zero
    input  logic [dhsc_pkg::M_TDATA_W-1:0]     i_m_tdata,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [dhsc_pkg::ADDR_W-1:0]        i_paddr,
    input  logic [dhsc_pkg::DATA_W-1:0]        i_pwdata,
    input  logic                               i_pready,
    output int                                 o_pending,
    output int                                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dhsc_pkg::ADDR_W-1:0] KEY_ADDR =
        dhsc_pkg::ADDR_W'(4 * dhsc_pkg::REG_KEY_IDX);
    localparam int MAX_REPORTS = 10;
    localparam int unsigned MAJOR_STEPS [7] = '{0, 2, 4, 5, 7, 9, 11};

    typedef struct packed {
        logic [2:0][8:0] shift;
        logic [2:0][3:0] harm;
        logic [3:0]      note;
    } harmony_t;

    harmony_t   pending_harmonies [$];
    logic [3:0] key_sig;
    int         fail_total = 0;
    int         results_seen = 0;

    // Nearest semitone class: count half-semitone steps with pitch^24 >= 440^24 * 2^n.
    function automatic int semitone_class(input logic [15:0] pitch);
        logic [447:0] pw;
        logic [447:0] bound;
        int           steps;
        int           i;
        pw    = 448'd1;
        bound = 448'd1;
        for (i = 0; i < 24; i++) begin
            pw    = pw * 448'(pitch);
            bound = bound * 448'd440;
        end
        steps = 0;
        while ((bound << 1) <= pw) begin
            bound = bound << 1;
            steps++;
        end
        return ((steps + 1) / 2) % 12;
    endfunction

    // Off-scale notes take the degree of the note below, with no wrap below A.
    function automatic int scale_degree(input int root, input int note);
        int k;
        int d;
        for (k = 0; k < 2; k++) begin
            for (d = 0; d < 7; d++) begin
                if (note - k == int'((root + MAJOR_STEPS[d]) % 12)) return d;
            end
        end
        return 0;
    endfunction

    function automatic harmony_t predict_harmony(input logic [3:0] key, input logic [15:0] pitch,
                                                 input logic [10:0] hand_dist);
        harmony_t res;
        int       root;
        int       note;
        int       deg;
        int       r;
        int       e;
        int       frac;
        int       h;
        int       s;
        int       m;
        res = '0;
        if (pitch == 16'd0) return res;
        root = (int'(key) + 3) % 12;
        note = semitone_class(pitch);
        deg  = scale_degree(root, note);
        r    = (int'(hand_dist) + 40) / 80;
        e    = int'(hand_dist) - 80 * r;
        frac = (e >= 0) ? (e + 2) / 5 : -((2 - e) / 5);
        res.note = note[3:0];
        for (m = 1; m <= 3; m++) begin
            h = (root + int'(MAJOR_STEPS[(deg + r * m) % 7])) % 12;
            s = (h - note) * 16 + frac;
            if (s > 96) s -= 192;
            res.harm[m-1]  = h[3:0];
            res.shift[m-1] = s[8:0];
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %0d got %0d",
                         $realtime, results_seen, name, want, got);
        end
    endtask

    task automatic compare_result(input harmony_t want, input harmony_t got);
        int i;
        check_field("input_note", want.note, got.note);
        for (i = 0; i < 3; i++) begin
            check_field($sformatf("harmony_%0d_note", i + 1), want.harm[i], got.harm[i]);
            check_field($sformatf("harmony_%0d_shift", i + 1),
                        $signed(want.shift[i]), $signed(got.shift[i]));
        end
    endtask

    always @(posedge i_clk) begin : watch
        harmony_t got;
        if (!i_rst_n) begin
            key_sig = '0;
            pending_harmonies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.note     = i_m_tdata[3:0];
                got.harm[0]  = i_m_tdata[7:4];
                got.harm[1]  = i_m_tdata[11:8];
                got.harm[2]  = i_m_tdata[15:12];
                got.shift[0] = i_m_tdata[24:16];
                got.shift[1] = i_m_tdata[33:25];
                got.shift[2] = i_m_tdata[42:34];
                results_seen++;
                if (pending_harmonies.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS)
                        $display("%0t: result %0d arrived with none outstanding, tdata %h",
                                 $realtime, results_seen, i_m_tdata);
                end else begin
                    compare_result(pending_harmonies.pop_front(), got);
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_harmonies.push_back(predict_harmony(key_sig, i_s_tdata[15:0],
                                                            i_s_tdata[26:16]));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == KEY_ADDR)
                key_sig = i_pwdata[3:0];
        end
        o_pending    <= pending_harmonies.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- verif/tb_diatonic_harmony_shift_calc_core.sv -----
// Stimulus and verdict for the diatonic harmony shift calculator core.
module tb_diatonic_harmony_shift_calc_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dhsc_pkg::ADDR_W-1:0] KEY_ADDR =
        dhsc_pkg::ADDR_W'(4 * dhsc_pkg::REG_KEY_IDX);
    // Idle wait before the verdict, with margin beyond the time a result takes to emerge.
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 150;
    localparam int IDLE_PERCENT   = 12;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dhsc_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [dhsc_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [dhsc_pkg::ADDR_W-1:0]     paddr = '0;
    logic [dhsc_pkg::DATA_W-1:0]     pwdata = '0;
    logic [dhsc_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    // High during the stretch where neither side idles.
    logic                            quiet = 1'b0;

    int                              pending;
    int                              fail_count;

    always #5 i_clk = ~i_clk;

    diatonic_harmony_shift_calc_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    harmony_shift_watch shift_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Result side: stall at random, except during the quiet stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Present one transaction, with a random gap in front of it, and hold it until accepted.
    task automatic send_item(input logic [15:0] pitch, input logic [10:0] hand_dist);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, hand_dist, pitch};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // APB write of the key root, a setup phase then an access phase; the block is idle whenever this runs.
    task automatic write_key(input logic [3:0] key);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= dhsc_pkg::DATA_W'(key);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random transaction: mostly musical pitches, some silence, sub-27.5 Hz and raw values;
    // a quarter of the distances sit close to the interval rounding edges.
    task automatic send_random_item();
        logic [15:0] pitch;
        logic [10:0] hand_dist;
        int          sel;
        int          near;
        sel = $urandom_range(99);
        if (sel < 5)       pitch = 16'd0;
        else if (sel < 15) pitch = 16'($urandom_range(439, 1));
        else if (sel < 30) pitch = 16'($urandom());
        else               pitch = 16'($urandom_range(65535, 440));
        sel = $urandom_range(99);
        if (sel < 25) begin
            near = 80 * $urandom_range(25) + 40 + $urandom_range(6) - 3;
            hand_dist = (near > 2047) ? 11'd2047 : 11'(near);
        end else begin
            hand_dist = 11'($urandom());
        end
        send_item(pitch, hand_dist);
    endtask

    initial begin : stimulus
        int i;
        int ph;
        int n;
        logic [3:0] key;

        // Synchronous reset, applied once at the start.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed transactions under the reset key (C major).
        // No pitch: all-zero result, whatever the distance.
        send_item(16'd0, 11'd1234);
        send_item(16'd0, 11'd2047);
        // Low pitch clamp, and the 27.5 Hz edge.
        send_item(16'd1, 11'd0);
        send_item(16'd439, 11'd40);
        send_item(16'd440, 11'd39);
        send_item(16'd441, 11'd79);
        // Top of the pitch range, distance extremes and rounding edges.
        send_item(16'hFFFF, 11'd2047);
        send_item(16'hFFFF, 11'd80);
        send_item(16'h8000, 11'd119);
        send_item(16'd7040, 11'd120);
        // One pitch per semitone class across the octave above 440 Hz.
        for (i = 0; i < 12; i++)
            send_item(16'($rtoi(7040.0 * (2.0 ** (i / 12.0)))), 11'(i * 173));
        drain_results();

        // Random phases over several keys, the out-of-range roots among them.
        for (ph = 0; ph < 11; ph++) begin
            case (ph)
                0:       key = 4'd11;
                1:       key = 4'd0;
                2:       key = 4'd12;
                3:       key = 4'd13;
                4:       key = 4'd14;
                5:       key = 4'd15;
                default: key = 4'($urandom_range(10, 1));
            endcase
            write_key(key);
            quiet <= (ph == 6);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
                // Hold the sender mid-phase until the pipeline is empty.
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
            end
            drain_results();
        end

        // Let any stray result surface before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dhsc_pkg.sv
src/dhsc_front.sv
src/dhsc_queue.sv
src/dhsc_back.sv
src/diatonic_harmony_shift_calc_core.sv
src/dhsc_chk.sv
verif/harmony_shift_watch.sv
verif/tb_diatonic_harmony_shift_calc_core.sv
